// ----- sv/knx2f_pkg.sv -----
// Shared types and constants for the two-byte bus float codec.
// No dependencies; used by knx2f_datapath, knx2f_seq and the top level.
package knx2f_pkg;

	localparam int WORD_W  = 16;
	localparam int VAL_W   = 27;
	localparam int IN_W    = 28;
	localparam int EXP_W   = 4;
	localparam int MANT_W  = 11;
	localparam int Q_W     = 12;

	localparam logic [EXP_W-1:0] EXP_MAX = 4'hf;
	localparam logic signed [IN_W-1:0] MANT_MAX = 28'sd2047;
	localparam logic signed [IN_W-1:0] MANT_MIN = -28'sd2048;

	localparam logic ACT_DECODE = 1'b0;
	localparam logic ACT_ENCODE = 1'b1;

	// sequencer -> datapath
	typedef struct packed {
		logic load;
		logic step;
	} knx2f_ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic exp_zero;
		logic exp_last;
		logic fits;
	} knx2f_stat_t;

endpackage

// ----- sv/knx2f_datapath.sv -----
// Shared one-bit shifter datapath: accumulator, exponent counter, range bounds.
// Depends on knx2f_pkg.
module knx2f_datapath import knx2f_pkg::*; (
	input  logic                     clk,
	input  knx2f_ctrl_t              ctrl,
	input  logic                     action,
	input  logic [WORD_W-1:0]        encoded_in,
	input  logic signed [IN_W-1:0]   value_in,
	output knx2f_stat_t              stat,
	output logic [WORD_W-1:0]        res_encoded,
	output logic signed [VAL_W-1:0]  res_value,
	output logic                     res_saturated
);

	logic [IN_W-1:0]        acc_q;
	logic [EXP_W-1:0]       exp_q;
	logic signed [IN_W-1:0] value_q;
	logic signed [IN_W-1:0] hi_q;
	logic signed [IN_W-1:0] lo_q;
	logic                   rbit_q;
	logic                   neg_q;
	logic                   mode_q;

	logic signed [IN_W-1:0] dec_mant;
	logic [IN_W-1:0]        mag;
	logic [Q_W-1:0]         q;
	logic [Q_W-1:0]         m12;
	logic                   fits;

	assign dec_mant = {{(IN_W-MANT_W){encoded_in[WORD_W-1]}}, encoded_in[MANT_W-1:0]};
	assign mag      = value_in[IN_W-1] ? IN_W'(-value_in) : IN_W'(value_in);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mode_q  <= action;
			value_q <= value_in;
			neg_q   <= value_in[IN_W-1];
			hi_q    <= MANT_MAX;
			lo_q    <= MANT_MIN;
			rbit_q  <= 1'b0;
			if (action == ACT_ENCODE) begin
				acc_q <= mag;
				exp_q <= '0;
			end else begin
				acc_q <= dec_mant;
				exp_q <= encoded_in[WORD_W-2 -: EXP_W];
			end
		end else if (ctrl.step) begin
			if (mode_q == ACT_ENCODE) begin
				// divide by two; keep the last bit out for rounding
				acc_q  <= acc_q >> 1;
				rbit_q <= acc_q[0];
				hi_q   <= hi_q <<< 1;
				lo_q   <= lo_q <<< 1;
				exp_q  <= exp_q + 1'b1;
			end else begin
				acc_q <= acc_q << 1;
				exp_q <= exp_q - 1'b1;
			end
		end
	end

	assign fits = (value_q <= hi_q) && (value_q >= lo_q);

	assign stat.exp_zero = (exp_q == '0);
	assign stat.exp_last = (exp_q == EXP_MAX);
	assign stat.fits     = fits;

	// once in range acc holds at most 2048, so 12 bits carry the quotient
	assign q   = acc_q[Q_W-1:0] + Q_W'(rbit_q);
	assign m12 = neg_q ? Q_W'(-q) : q;

	always_comb begin
		res_encoded   = '0;
		res_value     = '0;
		res_saturated = 1'b0;
		if (mode_q == ACT_ENCODE) begin
			if (fits) begin
				res_encoded = {m12[Q_W-1], exp_q, m12[MANT_W-1:0]};
			end else begin
				res_saturated = 1'b1;
				res_encoded   = {neg_q, EXP_MAX, {MANT_W{~neg_q}}};
			end
		end else begin
			res_value = acc_q[VAL_W-1:0];
		end
	end

endmodule

// ----- sv/knx2f_seq.sv -----
// Sequencer for the codec: loads an item, steps the shifter, signals finish.
// Depends on knx2f_pkg.
module knx2f_seq import knx2f_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        action,
	input  knx2f_stat_t stat,
	output knx2f_ctrl_t ctrl,
	output logic        busy,
	output logic        finish
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEC,
		S_ENC
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (action == ACT_ENCODE) ? S_ENC : S_DEC;
					end
				end
				S_DEC: begin
					if (stat.exp_zero) begin
						state_q <= S_IDLE;
					end
				end
				S_ENC: begin
					if (stat.fits || stat.exp_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl.load = 1'b0;
		ctrl.step = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			S_IDLE: ctrl.load = start;
			S_DEC: begin
				finish    = stat.exp_zero;
				ctrl.step = ~stat.exp_zero;
			end
			S_ENC: begin
				finish    = stat.fits || stat.exp_last;
				ctrl.step = ~(stat.fits || stat.exp_last);
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- sv/knx_two_byte_float_codec.sv -----
// Top level of the two-byte bus float codec (decode and encode).
// Depends on knx2f_pkg, knx2f_datapath, knx2f_seq.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+---------------------------
//  command | action, encoded_in, value_in         | start && !busy
//  result  | encoded_out, value_out, saturated    | done, one cycle, no stall
//
// done is the sequencer's finish, registered; finish comes when decode has counted the
// exponent down to zero, or when encode fits or reaches the top exponent, 15. A new item can be
// accepted in the done cycle. Decode shifts the mantissa left once per cycle, encode
// searches the exponent upward with one right shift per cycle, both in the same
// one-bit shifter. busy is high from accept until the finishing cycle.
// Reset clears the sequencer and the done strobe; payload is not reset.
module knx_two_byte_float_codec import knx2f_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic [WORD_W-1:0]        encoded_in,
	input  logic signed [IN_W-1:0]   value_in,
	output logic                     done,
	output logic [WORD_W-1:0]        encoded_out,
	output logic signed [VAL_W-1:0]  value_out,
	output logic                     saturated
);

	knx2f_ctrl_t             ctrl;
	knx2f_stat_t             stat;
	logic                    finish;
	logic [WORD_W-1:0]       res_encoded;
	logic signed [VAL_W-1:0] res_value;
	logic                    res_saturated;
	logic                    done_q;
	logic [WORD_W-1:0]       encoded_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    saturated_q;

	knx2f_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.finish (finish)
	);

	knx2f_datapath u_dp (
		.clk           (clk),
		.ctrl          (ctrl),
		.action        (action),
		.encoded_in    (encoded_in),
		.value_in      (value_in),
		.stat          (stat),
		.res_encoded   (res_encoded),
		.res_value     (res_value),
		.res_saturated (res_saturated)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			encoded_q   <= res_encoded;
			value_q     <= res_value;
			saturated_q <= res_saturated;
		end
	end

	assign done        = done_q;
	assign encoded_out = encoded_q;
	assign value_out   = value_q;
	assign saturated   = saturated_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_sat_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (encoded_out[14:11] == EXP_MAX))
		else $error("saturated result without top exponent");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (value_out != '0)) |-> ((encoded_out == '0) && !saturated))
		else $error("decode result carries encode fields");
`endif

endmodule
